### hdl/gedt_pkg.sv
`timescale 1ns / 1ps

package gedt_pkg;

  localparam int unsigned MaxPins   = 32;
  localparam int unsigned MsPerSec  = 1000;
  localparam int unsigned UsPerSec  = 1000000;

  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned UsecW     = 20;
  localparam int unsigned PinIdxW   = 5;

  typedef enum logic [CfgAddrW-1:0] {
    REG_TIME_BASE_SEC  = 3'd0,
    REG_TIME_BASE_USEC = 3'd1,
    REG_TIME_BASE_TICK = 3'd2,
    REG_DEBOUNCE_MS    = 3'd3,
    REG_PIN_ENABLE     = 3'd4
  } cfg_reg_e;

  localparam logic [31:0] DebounceRst  = 32'd50;
  localparam logic [31:0] PinEnableRst = 32'h0000_3800;

  // one entry of the per-pin table
  typedef struct packed {
    logic [31:0] count;
    logic [31:0] tick;
  } pin_rec_t;

endpackage

### hdl/gpio_event_debounce_timestamper.sv
`timescale 1ns / 1ps

// channel | direction | handshake                  | payload
// in      | in        | in_valid_i / in_stall_o    | irq_status_i, now_tick_i, pin_levels_i
// out     | out       | out_valid_o / out_stall_i  | pin_index_o, trigger_count_o, pin_level_o,
//         |           |                            | stamp_sec_o, stamp_usec_o, last_of_run_o
// cfg     | in        | cfg_we_i                   | cfg_addr_i, cfg_wdata_i
//
// one item at a time: after a transfer the scan visits each pending enabled pin with a table
// read, then a check and write back, and then finishes before it takes the next item.
// the timestamp is built in steps after the transfer (reciprocal multiply, remainder,
// microseconds, carry); a held hit waits on it before it moves to the output.
// the per-pin table has a registered read; reset clears its per-entry valid bits at once.
// a stalled output holds the scan; a new item is taken once the last result sits in the
// output register.

module gpio_event_debounce_timestamper #(
  parameter int unsigned NUM_PINS = gedt_pkg::MaxPins
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [31:0]                   irq_status_i,
  input  logic [31:0]                   now_tick_i,
  input  logic [31:0]                   pin_levels_i,

  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [gedt_pkg::PinIdxW-1:0]  pin_index_o,
  output logic [31:0]                   trigger_count_o,
  output logic                          pin_level_o,
  output logic [31:0]                   stamp_sec_o,
  output logic [gedt_pkg::UsecW-1:0]    stamp_usec_o,
  output logic                          last_of_run_o,

  input  logic                          cfg_we_i,
  input  logic [gedt_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [gedt_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import gedt_pkg::*;

  localparam int unsigned AW = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
  localparam logic [31:0] PinRange = 32'((64'd1 << NUM_PINS) - 64'd1);
  // ceil(2^38 / 1000), exact quotient for every 32-bit dividend
  localparam logic [28:0] Recip = 29'h1062_4DD3;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_CHECK, S_FLUSH} scan_e;
  typedef enum logic [2:0] {T_IDLE, T_DIV, T_REM, T_FRAC, T_CARRY} stamp_e;

  // configuration registers
  logic [31:0]      base_sec_q;
  logic [UsecW-1:0] base_usec_q;
  logic [31:0]      base_tick_q;
  logic [31:0]      debounce_q;
  logic [31:0]      enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_sec_q  <= '0;
      base_usec_q <= '0;
      base_tick_q <= '0;
      debounce_q  <= DebounceRst;
      enable_q    <= PinEnableRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_TIME_BASE_SEC:  base_sec_q  <= cfg_wdata_i;
        REG_TIME_BASE_USEC: base_usec_q <= cfg_wdata_i[UsecW-1:0];
        REG_TIME_BASE_TICK: base_tick_q <= cfg_wdata_i;
        REG_DEBOUNCE_MS: begin
          if (cfg_wdata_i != '0) begin
            debounce_q <= cfg_wdata_i;
          end
        end
        REG_PIN_ENABLE:     enable_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  scan_e state_q;
  logic  in_xfer;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && (state_q == S_IDLE);

  // timestamp unit
  stamp_e           tstate_q;
  logic [31:0]      elapsed_q;
  logic [31:0]      quot_q;
  logic [9:0]       rem_q;
  logic [20:0]      usec_sum_q;
  logic [31:0]      stamp_sec_q;
  logic [UsecW-1:0] stamp_usec_q;
  logic             stamp_ready_q;

  logic [31:0] quot_d;
  logic [9:0]  rem_d;
  logic [1:0]  carry;
  logic [20:0] usec_full;

  always_comb begin
    quot_d = 32'((61'(elapsed_q) * 61'(Recip)) >> 38);
    rem_d  = 10'(elapsed_q - quot_q * 32'(MsPerSec));
  end

  always_comb begin
    if (usec_sum_q >= 21'(2 * UsPerSec)) begin
      carry     = 2'd2;
      usec_full = usec_sum_q - 21'(2 * UsPerSec);
    end else if (usec_sum_q >= 21'(UsPerSec)) begin
      carry     = 2'd1;
      usec_full = usec_sum_q - 21'(UsPerSec);
    end else begin
      carry     = 2'd0;
      usec_full = usec_sum_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tstate_q      <= T_IDLE;
      stamp_ready_q <= 1'b0;
    end else if (in_xfer) begin
      tstate_q      <= T_DIV;
      stamp_ready_q <= 1'b0;
    end else begin
      case (tstate_q)
        T_DIV:   tstate_q <= T_REM;
        T_REM:   tstate_q <= T_FRAC;
        T_FRAC:  tstate_q <= T_CARRY;
        T_CARRY: begin
          tstate_q      <= T_IDLE;
          stamp_ready_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      elapsed_q <= now_tick_i - base_tick_q;
    end else begin
      case (tstate_q)
        T_DIV:   quot_q <= quot_d;
        T_REM:   rem_q  <= rem_d;
        T_FRAC: begin
          usec_sum_q <= 21'(base_usec_q) + 21'(20'(rem_q) * 20'(MsPerSec));
        end
        T_CARRY: begin
          stamp_sec_q  <= base_sec_q + quot_q + 32'(carry);
          stamp_usec_q <= usec_full[UsecW-1:0];
        end
        default: ;
      endcase
    end
  end

  // per-pin table
  pin_rec_t              mem [NUM_PINS];
  logic [NUM_PINS-1:0]   entry_valid_q;
  pin_rec_t              rd_data_q;
  logic                  rd_valid_q;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  pin_rec_t              wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= '0;
      rd_valid_q    <= 1'b0;
    end else begin
      if (wr_en) begin
        entry_valid_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_q <= entry_valid_q[rd_addr];
      end
    end
  end

  // scan control
  logic [31:0]         scan_mask_q;
  logic [31:0]         now_q;
  logic [31:0]         levels_q;
  logic [AW-1:0]       cur_pin_q;

  logic                pend_valid_q;
  logic [PinIdxW-1:0]  pend_pin_q;
  logic [31:0]         pend_count_q;
  logic                pend_level_q;

  logic                out_valid_q;
  logic [PinIdxW-1:0]  out_pin_q;
  logic [31:0]         out_count_q;
  logic                out_level_q;
  logic [31:0]         out_sec_q;
  logic [UsecW-1:0]    out_usec_q;
  logic                out_last_q;

  logic [PinIdxW-1:0]  pick;
  pin_rec_t            prev;
  logic [31:0]         delta;
  logic                hit;
  logic                out_free;
  logic                can_move;
  logic                do_commit;
  logic                out_load;

  always_comb begin
    pick = '0;
    for (int i = 31; i >= 0; i--) begin
      if (scan_mask_q[i]) begin
        pick = PinIdxW'(i);
      end
    end
  end

  always_comb begin
    prev      = rd_valid_q ? rd_data_q : '0;
    delta     = now_q - prev.tick;
    hit       = (delta >= debounce_q);
    out_free  = !out_valid_q || !out_stall_i;
    can_move  = out_free && stamp_ready_q;
    do_commit = (state_q == S_CHECK) && hit && (!pend_valid_q || can_move);
    out_load  = (do_commit && pend_valid_q) ||
                ((state_q == S_FLUSH) && pend_valid_q && can_move);
  end

  assign rd_en   = (state_q == S_READ) && (scan_mask_q != '0);
  assign rd_addr = AW'(pick);
  assign wr_en   = do_commit;
  assign wr_addr = cur_pin_q;
  assign wr_data = '{count: prev.count + 32'd1, tick: now_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      scan_mask_q  <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            scan_mask_q <= irq_status_i & enable_q & PinRange;
            state_q     <= S_READ;
          end
        end
        S_READ: begin
          if (scan_mask_q != '0) begin
            scan_mask_q[pick] <= 1'b0;
            state_q           <= S_CHECK;
          end else begin
            state_q <= S_FLUSH;
          end
        end
        S_CHECK: begin
          if (!hit) begin
            state_q <= S_READ;
          end else if (do_commit) begin
            pend_valid_q <= 1'b1;
            state_q      <= S_READ;
          end
        end
        S_FLUSH: begin
          if (!pend_valid_q) begin
            state_q <= S_IDLE;
          end else if (can_move) begin
            pend_valid_q <= 1'b0;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      now_q    <= now_tick_i;
      levels_q <= pin_levels_i;
    end
    if (rd_en) begin
      cur_pin_q <= AW'(pick);
    end
    if (out_load) begin
      out_pin_q   <= pend_pin_q;
      out_count_q <= pend_count_q;
      out_level_q <= pend_level_q;
      out_sec_q   <= stamp_sec_q;
      out_usec_q  <= stamp_usec_q;
      // a held event pushed out by a new hit is not the last one
      out_last_q  <= (state_q == S_FLUSH);
    end
    if (do_commit) begin
      pend_pin_q   <= PinIdxW'(cur_pin_q);
      pend_count_q <= wr_data.count;
      pend_level_q <= levels_q[cur_pin_q];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pin_index_o     = out_pin_q;
  assign trigger_count_o = out_count_q;
  assign pin_level_o     = out_level_q;
  assign stamp_sec_o     = out_sec_q;
  assign stamp_usec_o    = out_usec_q;
  assign last_of_run_o   = out_last_q;

endmodule

### verif/gedt_event_checker.sv
`timescale 1ns / 1ps

module gedt_event_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [31:0]                   irq_status_i,
  input  logic [31:0]                   now_tick_i,
  input  logic [31:0]                   pin_levels_i,

  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [gedt_pkg::PinIdxW-1:0]  pin_index_i,
  input  logic [31:0]                   trigger_count_i,
  input  logic                          pin_level_i,
  input  logic [31:0]                   stamp_sec_i,
  input  logic [gedt_pkg::UsecW-1:0]    stamp_usec_i,
  input  logic                          last_of_run_i,

  input  logic                          cfg_we_i,
  input  logic [gedt_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [gedt_pkg::CfgDataW-1:0] cfg_wdata_i,

  output int                            fail_cnt_o,
  output int                            pending_o
);

  import gedt_pkg::*;

  typedef struct packed {
    logic [PinIdxW-1:0] pin;
    logic [31:0]        count;
    logic               level;
    logic [31:0]        sec;
    logic [UsecW-1:0]   usec;
    logic               last;
  } irq_event_t;

  irq_event_t  expected_events [$];

  logic [31:0]      base_sec;
  logic [UsecW-1:0] base_usec;
  logic [31:0]      base_tick;
  logic [31:0]      debounce;
  logic [31:0]      pin_mask;
  logic [31:0]      last_tick_tbl [MaxPins];
  logic [31:0]      count_tbl [MaxPins];

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t mismatch %s: got 0x%08h expected 0x%08h", $realtime, what, got, want);
    fail_cnt_o = fail_cnt_o + 1;
  endtask

  task automatic clear_model();
    int p;
    base_sec  = '0;
    base_usec = '0;
    base_tick = '0;
    debounce  = DebounceRst;
    pin_mask  = PinEnableRst;
    for (p = 0; p < MaxPins; p++) begin
      last_tick_tbl[p] = '0;
      count_tbl[p]     = '0;
    end
    expected_events.delete();
    fail_cnt_o = 0;
  endtask

  task automatic apply_cfg(input logic [CfgAddrW-1:0] addr, input logic [CfgDataW-1:0] data);
    case (addr)
      REG_TIME_BASE_SEC:  base_sec = data;
      REG_TIME_BASE_USEC: base_usec = data[UsecW-1:0];
      REG_TIME_BASE_TICK: base_tick = data;
      REG_DEBOUNCE_MS: begin
        // zero is not a legal lockout, the old value stays
        if (data != 32'd0) debounce = data;
      end
      REG_PIN_ENABLE:     pin_mask = data;
      default: ;
    endcase
  endtask

  // lockout check per pin in ascending order, then stamp each accepted trigger
  task automatic scan_pins(input logic [31:0] status, input logic [31:0] now,
                           input logic [31:0] levels);
    irq_event_t  found [MaxPins];
    int          n;
    int          p;
    logic [31:0] since;
    logic [31:0] elapsed;
    logic [31:0] usec_sum;
    n = 0;
    elapsed  = now - base_tick;
    usec_sum = {12'd0, base_usec} + (elapsed % MsPerSec) * MsPerSec;
    for (p = 0; p < MaxPins; p++) begin
      since = now - last_tick_tbl[p];
      if (status[p] && pin_mask[p] && since >= debounce) begin
        last_tick_tbl[p] = now;
        count_tbl[p]     = count_tbl[p] + 32'd1;
        found[n].pin   = p[PinIdxW-1:0];
        found[n].count = count_tbl[p];
        found[n].level = levels[p];
        found[n].sec   = base_sec + elapsed / MsPerSec + usec_sum / UsPerSec;
        found[n].usec  = UsecW'(usec_sum % UsPerSec);
        found[n].last  = 1'b0;
        n++;
      end
    end
    if (n > 0) found[n-1].last = 1'b1;
    for (p = 0; p < n; p++) expected_events.push_back(found[p]);
  endtask

  task automatic check_result();
    irq_event_t want;
    if (expected_events.size() == 0) begin
      flag_mismatch("result with nothing expected, pin", 32'(pin_index_i), 32'd0);
    end else begin
      want = expected_events.pop_front();
      if (pin_index_i !== want.pin)
        flag_mismatch("pin_index", 32'(pin_index_i), 32'(want.pin));
      if (trigger_count_i !== want.count)
        flag_mismatch("trigger_count", trigger_count_i, want.count);
      if (pin_level_i !== want.level)
        flag_mismatch("pin_level", 32'(pin_level_i), 32'(want.level));
      if (stamp_sec_i !== want.sec)
        flag_mismatch("stamp_sec", stamp_sec_i, want.sec);
      if (stamp_usec_i !== want.usec)
        flag_mismatch("stamp_usec", 32'(stamp_usec_i), 32'(want.usec));
      if (last_of_run_i !== want.last)
        flag_mismatch("last_of_run", 32'(last_of_run_i), 32'(want.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_model();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) apply_cfg(cfg_addr_i, cfg_wdata_i);
      // an outgoing transfer always belongs to an older item than a new input
      if (out_valid_i && !out_stall_i) check_result();
      if (in_valid_i && !in_stall_i) scan_pins(irq_status_i, now_tick_i, pin_levels_i);
      pending_o <= expected_events.size();
    end
  end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  import gedt_pkg::*;

  localparam int unsigned SettleCycles = 120;
  localparam int unsigned IdleLimit    = 4000;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned HoldAfter    = 45;

  localparam logic [CfgAddrW-1:0] RegSpareLow  = 3'd5;
  localparam logic [CfgAddrW-1:0] RegSpareHigh = 3'd7;

  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_HEAVY, RX_TOGGLE} rx_mode_e;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_valid   = 1'b0;
  logic [31:0]          irq_status = '0;
  logic [31:0]          now_tick   = '0;
  logic [31:0]          pin_levels = '0;
  logic                 out_stall  = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [CfgAddrW-1:0]  cfg_addr   = '0;
  logic [CfgDataW-1:0]  cfg_wdata  = '0;

  logic                 in_stall;
  logic                 out_valid;
  logic [PinIdxW-1:0]   pin_index;
  logic [31:0]          trigger_count;
  logic                 pin_level;
  logic [31:0]          stamp_sec;
  logic [UsecW-1:0]     stamp_usec;
  logic                 last_of_run;

  int                   fail_cnt;
  int                   pending;
  int                   items_sent  = 0;
  int                   idle_cycles = 0;
  logic [31:0]          tick_now    = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gpio_event_debounce_timestamper DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .irq_status_i    (irq_status),
    .now_tick_i      (now_tick),
    .pin_levels_i    (pin_levels),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .pin_index_o     (pin_index),
    .trigger_count_o (trigger_count),
    .pin_level_o     (pin_level),
    .stamp_sec_o     (stamp_sec),
    .stamp_usec_o    (stamp_usec),
    .last_of_run_o   (last_of_run),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata)
  );

  gedt_event_checker event_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .irq_status_i    (irq_status),
    .now_tick_i      (now_tick),
    .pin_levels_i    (pin_levels),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .pin_index_i     (pin_index),
    .trigger_count_i (trigger_count),
    .pin_level_i     (pin_level),
    .stamp_sec_i     (stamp_sec),
    .stamp_usec_i    (stamp_usec),
    .last_of_run_i   (last_of_run),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .fail_cnt_o      (fail_cnt),
    .pending_o       (pending)
  );

  // watchdog on cycles without any transfer or register write
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_item(input logic [31:0] status, input logic [31:0] tick,
                           input logic [31:0] levels);
    @(negedge clk);
    in_valid   <= 1'b1;
    irq_status <= status;
    now_tick   <= tick;
    pin_levels <= levels;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic hold_input(input int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // wait for every expected result, then let a zero-result scan finish
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CfgAddrW-1:0] addr, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_items(input int count, input logic [31:0] step_max,
                              input bit pause_midway);
    int          k;
    int          burst;
    logic [31:0] status;
    burst = 0;
    for (k = 0; k < count; k++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 8);
        if ($urandom_range(0, 3) != 0) hold_input($urandom_range(1, 6));
      end
      burst--;
      case ($urandom_range(0, 9))
        0:       status = $urandom;
        1, 2:    status = 32'd1 << $urandom_range(0, 31);
        3:       status = $urandom & $urandom & $urandom;
        default: status = $urandom & $urandom;
      endcase
      // mostly a tick that moves forward around the lockout, sometimes a jump
      if ($urandom_range(0, 9) == 0) tick_now = $urandom;
      else tick_now = tick_now + $urandom_range(0, step_max);
      send_item(status, tick_now, $urandom);
      if (pause_midway && k == count / 2) drain();
    end
  endtask

  // receiver stall pattern, with one long hold-off once traffic is running
  initial begin : rx_pattern
    rx_mode_e mode;
    int       span;
    bit       hold_armed;
    hold_armed = 1'b1;
    wait (rst_n);
    forever begin
      if (hold_armed && items_sent >= HoldAfter) begin
        hold_armed = 1'b0;
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (HoldCycles - 1) @(negedge clk);
      end
      mode = rx_mode_e'($urandom_range(0, 3));
      span = $urandom_range(4, 40);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          RX_FREE:   out_stall <= 1'b0;
          RX_COIN:   out_stall <= 1'($urandom_range(0, 1));
          RX_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
          RX_TOGGLE: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  initial begin : stimulus
    logic [31:0] deb;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // reset settings: pins 11..13 enabled, lockout of 50 ms from tick 0
    send_item(32'hFFFF_FFFF, 32'd10, 32'h0000_0000);
    send_item(32'hFFFF_FFFF, 32'd49, 32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFF, 32'd50, 32'h0000_2800);
    send_item(32'h0000_4000, 32'd200, 32'hFFFF_FFFF);
    drain();

    cfg_write(REG_TIME_BASE_SEC, 32'h1234_5678);
    cfg_write(REG_TIME_BASE_USEC, 32'd999999);
    cfg_write(REG_TIME_BASE_TICK, 32'd1000);
    cfg_write(REG_DEBOUNCE_MS, 32'd1);
    cfg_write(REG_PIN_ENABLE, 32'hFFFF_FFFF);
    cfg_write(RegSpareLow, 32'h0000_0000);
    cfg_write(RegSpareHigh, 32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFF, 32'd1000, 32'hAAAA_AAAA);
    send_item(32'h0000_0000, 32'd1999, 32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFF, 32'd1000, 32'h5555_5555);
    send_item(32'h8000_0001, 32'd1001, 32'h5555_5555);
    // tick before the time base: elapsed wraps
    send_item(32'hFFFF_FFFF, 32'd999, 32'hFFFF_FFFF);
    drain();

    // zero lockout is dropped, usec above range, seconds wrap
    cfg_write(REG_DEBOUNCE_MS, 32'd0);
    cfg_write(REG_TIME_BASE_USEC, 32'h000F_FFFF);
    cfg_write(REG_TIME_BASE_SEC, 32'hFFFF_FFFF);
    cfg_write(REG_TIME_BASE_TICK, 32'd0);
    send_item(32'h0000_0F0F, 32'd2000, 32'h0000_0A0A);
    send_item(32'h0000_0F0F, 32'd2000, 32'h0000_0505);
    drain();

    cfg_write(REG_DEBOUNCE_MS, 32'hFFFF_FFFF);
    cfg_write(REG_PIN_ENABLE, 32'h8000_0001);
    send_item(32'hFFFF_FFFF, 32'd3000, 32'hFFFF_FFFF);
    send_item(32'h0000_0001, 32'd1999, 32'hFFFF_FFFF);
    send_item(32'h8000_0000, 32'd998, 32'h8000_0000);
    drain();

    cfg_write(REG_PIN_ENABLE, 32'h0000_0000);
    send_item(32'hFFFF_FFFF, $urandom, $urandom);
    drain();

    // all pins, short lockout
    cfg_write(REG_TIME_BASE_SEC, $urandom);
    cfg_write(REG_TIME_BASE_USEC, $urandom_range(0, 999999));
    cfg_write(REG_TIME_BASE_TICK, $urandom);
    cfg_write(REG_DEBOUNCE_MS, 32'd20);
    cfg_write(REG_PIN_ENABLE, 32'hFFFF_FFFF);
    tick_now = $urandom;
    random_items(70, 32'd40, 1'b1);
    drain();

    cfg_write(REG_TIME_BASE_SEC, 32'hFFFF_FFFF);
    cfg_write(REG_TIME_BASE_USEC, 32'd999999);
    cfg_write(REG_TIME_BASE_TICK, tick_now);
    cfg_write(REG_DEBOUNCE_MS, 32'd1);
    cfg_write(REG_PIN_ENABLE, $urandom);
    random_items(60, 32'd3, 1'b0);
    drain();

    deb = $urandom_range(1, 5000);
    cfg_write(REG_TIME_BASE_SEC, $urandom);
    cfg_write(REG_TIME_BASE_USEC, 32'hFFFF_FFFF);
    cfg_write(REG_TIME_BASE_TICK, $urandom);
    cfg_write(REG_DEBOUNCE_MS, deb);
    cfg_write(REG_PIN_ENABLE, $urandom | $urandom);
    random_items(60, 2 * deb, 1'b0);
    drain();

    cfg_write(REG_TIME_BASE_SEC, 32'h0000_0000);
    cfg_write(REG_TIME_BASE_USEC, 32'h0000_0000);
    cfg_write(REG_TIME_BASE_TICK, tick_now);
    cfg_write(REG_DEBOUNCE_MS, DebounceRst);
    cfg_write(REG_PIN_ENABLE, $urandom);
    random_items(60, 32'd100, 1'b0);
    drain();

    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/gedt_pkg.sv
hdl/gpio_event_debounce_timestamper.sv
verif/gedt_event_checker.sv
verif/tb_top.sv
